/* rtl/cmcm_pkg.sv */
// Shared types, codes and helpers of the confusion matrix class metrics unit.
package cmcm_pkg;

    localparam int NUM_W    = 64;
    localparam int DEN_W    = 48;
    localparam int Q_W      = 17;
    localparam int NORM_BIT = 47;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

    typedef enum logic [1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_REPORT = 2'd1,
        FUNC_EPOCH  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        TREND_EQUAL = 2'd0,
        TREND_ROSE  = 2'd1,
        TREND_FELL  = 2'd2
    } trend_t;

    function automatic trend_t trend_of(input logic [Q_W-1:0] now,
                                        input logic [Q_W-1:0] earlier);
        trend_t t;
        if (now > earlier)
            t = TREND_ROSE;
        else if (now < earlier)
            t = TREND_FELL;
        else
            t = TREND_EQUAL;
        return t;
    endfunction

endpackage

/* rtl/cmcm_ram.sv */
// Count table memory with one write port and one registered read port.
module cmcm_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/cmcm_div.sv */
// Restoring divider that yields one quotient bit per cycle for the metric ratios.
module cmcm_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [cmcm_pkg::NUM_W-1:0] num,
    input  logic [cmcm_pkg::DEN_W-1:0] den,
    output logic                     done,
    output logic [cmcm_pkg::Q_W-1:0] quo
);
    import cmcm_pkg::*;

    logic [DEN_W:0]   rem_reg;
    logic [Q_W-1:0]   nsh_reg;
    logic [DEN_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg[DEN_W-1:0], nsh_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quo   = nsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            nsh_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= (DEN_W+1)'(num >> Q_W);
                nsh_reg <= num[Q_W-1:0];
                den_reg <= den;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
                nsh_reg <= {nsh_reg[Q_W-2:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(Q_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(run_reg)) else $error("divider done without a run");
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> quo <= ONE_Q16) else $error("quotient above one");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !start) else $error("divider started while running");
`endif

endmodule

/* rtl/confusion_matrix_class_metrics_unit.sv */
// Top level of the confusion matrix class metrics unit.
// The block counts (true, predicted) class pairs and reports per-class metrics.
// A word is accepted when start is high and busy is low; func selects record,
// report or epoch end. cfg_write loads cfg_data into active_reg.
// A record word is one read-modify-write of the current table.
// An epoch end swaps the two table banks and then clears the new current bank.
// A report word gives one word per active class on the result ports, marked by
// valid for one cycle, with last on the final class. Each class first reads
// its column and row of both tables, then runs six jobs in one shared divider:
// each ratio or F1 job loads, normalizes or multiplies, starts the divider and
// waits for it, with up to COUNT_BITS-40 normalizing shifts per ratio.
// After reset both banks are cleared with busy high. The receiver cannot
// stall; results are never held back.
module confusion_matrix_class_metrics_unit #(
    parameter int MAX_CLASSES = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [6:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [5:0]  true_class,
    input  logic [5:0]  predicted_class,
    output logic        valid,
    output logic [5:0]  class_index,
    output logic [16:0] precision,
    output logic [16:0] recall,
    output logic [16:0] f1_score,
    output logic [1:0]  precision_trend,
    output logic [1:0]  recall_trend,
    output logic [1:0]  f1_trend,
    output logic        last
);
    import cmcm_pkg::*;

    localparam int TABLE  = MAX_CLASSES * MAX_CLASSES;
    localparam int ADDR_W = $clog2(TABLE);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int SUM_W  = COUNT_BITS + 7;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_WR, S_SA, S_SB, S_LOAD, S_NORM, S_MUL, S_DST, S_DW, S_OUT
    } state_t;

    state_t              state_reg;
    logic [6:0]          active_reg;
    logic                sel_reg;
    logic                clr_both_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CLS_W-1:0]    c_reg;
    logic [CLS_W-1:0]    k_reg;
    logic                pass_reg;
    logic [SUM_W-1:0]    cur_col_reg, cur_row_reg, prev_col_reg, prev_row_reg;
    logic [SUM_W-1:0]    cur_tp_reg, prev_tp_reg;
    logic [SUM_W-1:0]    tp_reg, den_reg;
    logic [2*Q_W-1:0]    prod_reg;
    logic [2:0]          job_reg;
    logic [Q_W-1:0]      res_reg [6];
    logic                valid_reg, last_reg;
    logic [5:0]          class_reg;
    logic [Q_W-1:0]      p_out_reg, r_out_reg, f_out_reg;
    trend_t              pt_reg, rt_reg, ft_reg;

    logic [6:0]            n_live;
    logic [COUNT_BITS-1:0] rd0, rd1, cur_rd, prev_rd, wdata;
    logic                  clr_we, rec_we, we0, we1;
    logic                  div_start, div_done;
    logic [Q_W-1:0]        div_quo;
    logic [NUM_W-1:0]      div_num;
    logic                  is_f;

    function automatic logic [ADDR_W-1:0] idx(input logic [CLS_W-1:0] a,
                                              input logic [CLS_W-1:0] b);
        return ADDR_W'(a) * ADDR_W'(MAX_CLASSES) + ADDR_W'(b);
    endfunction

    assign n_live  = (active_reg > 7'(MAX_CLASSES)) ? 7'(MAX_CLASSES) : active_reg;
    assign cur_rd  = sel_reg ? rd1 : rd0;
    assign prev_rd = sel_reg ? rd0 : rd1;
    assign clr_we  = state_reg == S_CLR;
    assign rec_we  = state_reg == S_WR;
    assign we0     = (clr_we && (clr_both_reg || !sel_reg)) || (rec_we && !sel_reg);
    assign we1     = (clr_we && (clr_both_reg || sel_reg)) || (rec_we && sel_reg);
    assign wdata   = clr_we ? '0 : ((&cur_rd) ? cur_rd : cur_rd + COUNT_BITS'(1));
    assign is_f    = job_reg == 3'd2 || job_reg == 3'd5;
    assign div_start = state_reg == S_DST && den_reg != '0;
    assign div_num = is_f ? (NUM_W'({prod_reg, 1'b0}) + NUM_W'(den_reg >> 1))
                          : ((NUM_W'(tp_reg) << 16) + NUM_W'(den_reg >> 1));

    cmcm_ram #(.AW(ADDR_W), .DW(COUNT_BITS)) u_ram0 (
        .clk(clk), .we(we0), .waddr(addr_reg), .wdata(wdata), .raddr(addr_reg), .rdata(rd0)
    );
    cmcm_ram #(.AW(ADDR_W), .DW(COUNT_BITS)) u_ram1 (
        .clk(clk), .we(we1), .waddr(addr_reg), .wdata(wdata), .raddr(addr_reg), .rdata(rd1)
    );
    cmcm_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(DEN_W'(den_reg)), .done(div_done), .quo(div_quo)
    );

    assign busy            = state_reg != S_IDLE;
    assign valid           = valid_reg;
    assign class_index     = class_reg;
    assign precision       = p_out_reg;
    assign recall          = r_out_reg;
    assign f1_score        = f_out_reg;
    assign precision_trend = pt_reg;
    assign recall_trend    = rt_reg;
    assign f1_trend        = ft_reg;
    assign last            = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            active_reg   <= 7'd16;
            sel_reg      <= 1'b0;
            clr_both_reg <= 1'b1;
            addr_reg     <= '0;
            c_reg        <= '0;
            k_reg        <= '0;
            pass_reg     <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            prev_col_reg <= '0;
            prev_row_reg <= '0;
            cur_tp_reg   <= '0;
            prev_tp_reg  <= '0;
            tp_reg       <= '0;
            den_reg      <= '0;
            prod_reg     <= '0;
            job_reg      <= '0;
            valid_reg    <= 1'b0;
            last_reg     <= 1'b0;
            class_reg    <= '0;
            p_out_reg    <= '0;
            r_out_reg    <= '0;
            f_out_reg    <= '0;
            pt_reg       <= TREND_EQUAL;
            rt_reg       <= TREND_EQUAL;
            ft_reg       <= TREND_EQUAL;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (cfg_write)
            begin
                active_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == ADDR_W'(TABLE - 1))
                    begin
                        clr_both_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (func)
                            FUNC_RECORD:
                            begin
                                if (7'(true_class) < n_live && 7'(predicted_class) < n_live)
                                begin
                                    addr_reg  <= idx(true_class[CLS_W-1:0],
                                                     predicted_class[CLS_W-1:0]);
                                    state_reg <= S_RD;
                                end
                            end
                            FUNC_REPORT:
                            begin
                                if (n_live != 7'd0)
                                begin
                                    c_reg        <= '0;
                                    k_reg        <= '0;
                                    pass_reg     <= 1'b0;
                                    cur_col_reg  <= '0;
                                    cur_row_reg  <= '0;
                                    prev_col_reg <= '0;
                                    prev_row_reg <= '0;
                                    addr_reg     <= idx('0, '0);
                                    state_reg    <= S_SA;
                                end
                            end
                            FUNC_EPOCH:
                            begin
                                sel_reg   <= !sel_reg;
                                addr_reg  <= '0;
                                state_reg <= S_CLR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_WR;
                end
                S_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_SA:
                begin
                    state_reg <= S_SB;
                end
                S_SB:
                begin
                    if (!pass_reg)
                    begin
                        cur_col_reg  <= cur_col_reg + SUM_W'(cur_rd);
                        prev_col_reg <= prev_col_reg + SUM_W'(prev_rd);
                        if (k_reg == c_reg)
                        begin
                            cur_tp_reg  <= SUM_W'(cur_rd);
                            prev_tp_reg <= SUM_W'(prev_rd);
                        end
                    end
                    else
                    begin
                        cur_row_reg  <= cur_row_reg + SUM_W'(cur_rd);
                        prev_row_reg <= prev_row_reg + SUM_W'(prev_rd);
                    end
                    if (7'(k_reg) + 7'd1 == n_live)
                    begin
                        if (!pass_reg)
                        begin
                            pass_reg  <= 1'b1;
                            k_reg     <= '0;
                            addr_reg  <= idx(c_reg, '0);
                            state_reg <= S_SA;
                        end
                        else
                        begin
                            job_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + CLS_W'(1);
                        addr_reg  <= pass_reg ? idx(c_reg, k_reg + CLS_W'(1))
                                              : idx(k_reg + CLS_W'(1), c_reg);
                        state_reg <= S_SA;
                    end
                end
                S_LOAD:
                begin
                    case (job_reg)
                        3'd0:
                        begin
                            tp_reg  <= cur_tp_reg;
                            den_reg <= cur_col_reg;
                        end
                        3'd1:
                        begin
                            tp_reg  <= cur_tp_reg;
                            den_reg <= cur_row_reg;
                        end
                        3'd3:
                        begin
                            tp_reg  <= prev_tp_reg;
                            den_reg <= prev_col_reg;
                        end
                        3'd4:
                        begin
                            tp_reg  <= prev_tp_reg;
                            den_reg <= prev_row_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= is_f ? S_MUL : S_NORM;
                end
                S_NORM:
                begin
                    if ((den_reg >> NORM_BIT) != '0)
                    begin
                        den_reg <= den_reg >> 1;
                        tp_reg  <= tp_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= S_DST;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= res_reg[job_reg - 3'd2] * res_reg[job_reg - 3'd1];
                    den_reg   <= SUM_W'(res_reg[job_reg - 3'd2])
                               + SUM_W'(res_reg[job_reg - 3'd1]);
                    state_reg <= S_DST;
                end
                S_DST:
                begin
                    if (den_reg == '0)
                    begin
                        res_reg[job_reg] <= '0;
                        job_reg          <= job_reg + 3'd1;
                        state_reg        <= (job_reg == 3'd5) ? S_OUT : S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_DW;
                    end
                end
                S_DW:
                begin
                    if (div_done)
                    begin
                        res_reg[job_reg] <= div_quo;
                        job_reg          <= job_reg + 3'd1;
                        state_reg        <= (job_reg == 3'd5) ? S_OUT : S_LOAD;
                    end
                end
                S_OUT:
                begin
                    valid_reg    <= 1'b1;
                    class_reg    <= 6'(c_reg);
                    p_out_reg    <= res_reg[0];
                    r_out_reg    <= res_reg[1];
                    f_out_reg    <= res_reg[2];
                    pt_reg       <= trend_of(res_reg[0], res_reg[3]);
                    rt_reg       <= trend_of(res_reg[1], res_reg[4]);
                    ft_reg       <= trend_of(res_reg[2], res_reg[5]);
                    last_reg     <= 7'(c_reg) + 7'd1 == n_live;
                    cur_col_reg  <= '0;
                    cur_row_reg  <= '0;
                    prev_col_reg <= '0;
                    prev_row_reg <= '0;
                    pass_reg     <= 1'b0;
                    k_reg        <= '0;
                    if (7'(c_reg) + 7'd1 == n_live)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CLS_W'(1);
                        addr_reg  <= idx('0, c_reg + CLS_W'(1));
                        state_reg <= S_SA;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy) else $error("report ended before its last word");
    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !valid) else $error("word after the last class");
    a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> precision <= ONE_Q16 && recall <= ONE_Q16 && f1_score <= ONE_Q16)
        else $error("metric above one");
`endif

endmodule

/* test/confusion_matrix_class_metrics_unit_test.sv */
// Testbench of the confusion matrix class metrics unit: directed table, then random words.
module confusion_matrix_class_metrics_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cmcm_pkg::*;

    localparam int MAX_CLASSES = 16;
    localparam int TABLE_SIZE = MAX_CLASSES * MAX_CLASSES;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [63:0] HALVE_LIMIT = 64'd1 << 47;

    typedef struct packed {
        logic [5:0]  class_index;
        logic [16:0] precision;
        logic [16:0] recall;
        logic [16:0] f1_score;
        logic [1:0]  precision_trend;
        logic [1:0]  recall_trend;
        logic [1:0]  f1_trend;
        logic        last;
    } metrics_t;

    typedef struct {
        logic [1:0] func;
        logic [5:0] true_class;
        logic [5:0] predicted_class;
        bit         zero_report;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [6:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [5:0]  true_class;
    logic [5:0]  predicted_class;
    logic        valid;
    logic [5:0]  class_index;
    logic [16:0] precision;
    logic [16:0] recall;
    logic [16:0] f1_score;
    logic [1:0]  precision_trend;
    logic [1:0]  recall_trend;
    logic [1:0]  f1_trend;
    logic        last;

    logic [63:0] current_counts [TABLE_SIZE];
    logic [63:0] previous_counts [TABLE_SIZE];
    logic [6:0]  class_count_reg;
    metrics_t    pending_metrics [$];
    bit          failed;
    longint      cycle_count;

    confusion_matrix_class_metrics_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .true_class      (true_class),
        .predicted_class (predicted_class),
        .valid           (valid),
        .class_index     (class_index),
        .precision       (precision),
        .recall          (recall),
        .f1_score        (f1_score),
        .precision_trend (precision_trend),
        .recall_trend    (recall_trend),
        .f1_trend        (f1_trend),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int live_classes();
        return (class_count_reg > MAX_CLASSES) ? MAX_CLASSES : int'(class_count_reg);
    endfunction

    function automatic logic [16:0] class_ratio(bit use_previous, int cls, int n, bit by_column);
        logic [63:0] tp;
        logic [63:0] total;
        logic [63:0] v;
        tp = use_previous ? previous_counts[cls * MAX_CLASSES + cls]
                          : current_counts[cls * MAX_CLASSES + cls];
        total = tp;
        for (int k = 0; k < n; k++)
        begin
            if (k != cls)
            begin
                if (by_column)
                    v = use_previous ? previous_counts[k * MAX_CLASSES + cls]
                                     : current_counts[k * MAX_CLASSES + cls];
                else
                    v = use_previous ? previous_counts[cls * MAX_CLASSES + k]
                                     : current_counts[cls * MAX_CLASSES + k];
                total += v;
            end
        end
        if (total == 0)
            return '0;
        while (total >= HALVE_LIMIT)
        begin
            total = total >> 1;
            tp = tp >> 1;
        end
        return 17'(((tp << 16) + (total >> 1)) / total);
    endfunction

    function automatic logic [16:0] f1_of(logic [16:0] p, logic [16:0] r);
        logic [63:0] s;
        s = 64'(p) + 64'(r);
        if (s == 0)
            return '0;
        return 17'((64'd2 * p * r + (s >> 1)) / s);
    endfunction

    function automatic logic [1:0] trend_code(logic [16:0] now, logic [16:0] earlier);
        if (now > earlier)
            return TREND_ROSE;
        if (now < earlier)
            return TREND_FELL;
        return TREND_EQUAL;
    endfunction

    task automatic apply_word(logic [1:0] f, logic [5:0] t, logic [5:0] p, bit zero_report);
        int n;
        metrics_t m;
        logic [16:0] pp;
        logic [16:0] pr;
        n = live_classes();
        if (f == FUNC_RECORD)
        begin
            if (t < n && p < n && current_counts[t * MAX_CLASSES + p] < 64'hFFFF_FFFF)
                current_counts[t * MAX_CLASSES + p]++;
        end
        else if (f == FUNC_EPOCH)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                previous_counts[i] = current_counts[i];
                current_counts[i] = '0;
            end
        end
        else if (f == FUNC_REPORT)
        begin
            for (int c = 0; c < n; c++)
            begin
                m = '0;
                m.class_index = 6'(c);
                m.last = (c == n - 1);
                m.precision_trend = TREND_EQUAL;
                m.recall_trend = TREND_EQUAL;
                m.f1_trend = TREND_EQUAL;
                if (!zero_report)
                begin
                    m.precision = class_ratio(1'b0, c, n, 1'b1);
                    m.recall = class_ratio(1'b0, c, n, 1'b0);
                    m.f1_score = f1_of(m.precision, m.recall);
                    pp = class_ratio(1'b1, c, n, 1'b1);
                    pr = class_ratio(1'b1, c, n, 1'b0);
                    m.precision_trend = trend_code(m.precision, pp);
                    m.recall_trend = trend_code(m.recall, pr);
                    m.f1_trend = trend_code(m.f1_score, f1_of(pp, pr));
                end
                pending_metrics.push_back(m);
            end
        end
    endtask

    task automatic send_word(logic [1:0] f, logic [5:0] t, logic [5:0] p, bit zero_report);
        start <= 1'b1;
        func <= f;
        true_class <= t;
        predicted_class <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_word(f, t, p, zero_report);
        @(negedge clk);
    endtask

    task automatic idle_gap(bit allowed);
        if (allowed && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1))
                @(negedge clk);
        end
    endtask

    task automatic write_class_count(logic [6:0] value);
        start <= 1'b0;
        while (pending_metrics.size() != 0 || busy)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        class_count_reg = value;
    endtask

    task automatic check_field(string name, logic [16:0] expected, logic [16:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        metrics_t m;
        if (rst_n && valid)
        begin
            if (pending_metrics.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual class %0d",
                         $time, class_index);
                failed = 1'b1;
            end
            else
            begin
                m = pending_metrics.pop_front();
                check_field("class_index", m.class_index, class_index);
                check_field("precision", m.precision, precision);
                check_field("recall", m.recall, recall);
                check_field("f1_score", m.f1_score, f1_score);
                check_field("precision_trend", m.precision_trend, precision_trend);
                check_field("recall_trend", m.recall_trend, recall_trend);
                check_field("f1_trend", m.f1_trend, f1_trend);
                check_field("last", m.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    table_row_t directed [] = '{
        '{FUNC_REPORT, 6'd0, 6'd0, 1'b1},
        '{FUNC_RECORD, 6'd0, 6'd0, 1'b0},
        '{FUNC_RECORD, 6'd15, 6'd15, 1'b0},
        '{FUNC_RECORD, 6'd63, 6'd63, 1'b0},
        '{FUNC_RECORD, 6'd0, 6'd63, 1'b0},
        '{FUNC_RECORD, 6'd63, 6'd0, 1'b0},
        '{FUNC_RECORD, 6'd16, 6'd1, 1'b0},
        '{FUNC_RECORD, 6'd42, 6'd21, 1'b0},
        '{FUNC_RECORD, 6'd1, 6'd2, 1'b0},
        '{FUNC_RECORD, 6'd2, 6'd1, 1'b0},
        '{FUNC_RECORD, 6'd1, 6'd1, 1'b0},
        '{FUNC_UNUSED, 6'd63, 6'd63, 1'b0},
        '{FUNC_REPORT, 6'd0, 6'd0, 1'b0},
        '{FUNC_EPOCH, 6'd0, 6'd0, 1'b0},
        '{FUNC_REPORT, 6'd0, 6'd0, 1'b0},
        '{FUNC_RECORD, 6'd3, 6'd3, 1'b0},
        '{FUNC_RECORD, 6'd3, 6'd4, 1'b0},
        '{FUNC_RECORD, 6'd1, 6'd1, 1'b0},
        '{FUNC_REPORT, 6'd0, 6'd0, 1'b0},
        '{FUNC_EPOCH, 6'd0, 6'd0, 1'b0},
        '{FUNC_EPOCH, 6'd0, 6'd0, 1'b0},
        '{FUNC_REPORT, 6'd0, 6'd0, 1'b1}
    };

    logic [6:0] class_count_plan [] = '{7'd1, 7'd64, 7'd0, 7'd2, 7'd5, 7'd127, 7'd16};

    initial
    begin
        int n;
        int pick;
        logic [1:0] f;
        logic [5:0] t;
        logic [5:0] p;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        func = FUNC_RECORD;
        true_class = '0;
        predicted_class = '0;
        failed = 1'b0;
        cycle_count = 0;
        class_count_reg = 7'd16;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            current_counts[i] = '0;
            previous_counts[i] = '0;
        end
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_word(directed[i].func, directed[i].true_class,
                      directed[i].predicted_class, directed[i].zero_report);
            idle_gap(1'b1);
        end

        foreach (class_count_plan[ph])
        begin
            write_class_count(class_count_plan[ph]);
            n = live_classes();
            for (int i = 0; i < 62; i++)
            begin
                pick = $urandom_range(99);
                t = 6'($urandom_range(63));
                p = 6'($urandom_range(63));
                if (pick < 3)
                    f = FUNC_UNUSED;
                else if (pick < 7)
                    f = FUNC_EPOCH;
                else if (pick < 11)
                    f = FUNC_REPORT;
                else
                begin
                    f = FUNC_RECORD;
                    if (n > 0 && $urandom_range(99) < 85)
                    begin
                        t = 6'($urandom_range(n - 1));
                        p = ($urandom_range(2) == 0) ? t : 6'($urandom_range(n - 1));
                    end
                end
                send_word(f, t, p, 1'b0);
                idle_gap(ph != class_count_plan.size() - 1);
            end
            send_word(FUNC_REPORT, 6'd0, 6'd0, 1'b0);
        end

        start <= 1'b0;
        while (pending_metrics.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (!failed && pending_metrics.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
